// ----- src/nns_pkg.sv -----
// Package for the nearest neighbor scan block: sequencer state type and fixed codes.
// Used by nearest_neighbor_scan_top; no other dependencies.
package nns_pkg;

  // Command codes of the input item.
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Metric codes of the configuration register.
  localparam logic METRIC_EUCLID = 1'b0;
  localparam logic METRIC_COSINE = 1'b1;

  // One in Q1.16.
  localparam logic [31:0] Q_ONE = 32'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_MUL,
    S_Q_ACC,
    S_D_RD,
    S_D_MUL1,
    S_D_MUL2,
    S_D_MUL3,
    S_D_ACC,
    S_F_START,
    S_EUC_SQ,
    S_COS_SQ1,
    S_COS_SQ2,
    S_COS_MUL,
    S_COS_DIVL,
    S_COS_DIV,
    S_COMPARE
  } state_t;

  typedef enum logic {
    E_IDLE,
    E_WAIT
  } emit_t;

endpackage

// ----- src/nns_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module nns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read on the one port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/nns_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// No dependencies.
module nns_sqrt #(
  parameter int NW = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NW-1:0]          n,
  output logic [(NW+1)/2-1:0]    root,
  output logic                   done
);

  localparam int RW = (NW + 1) / 2;
  localparam int SW = 2 * RW;
  localparam int CNW = $clog2(RW + 1);

  logic [SW-1:0]  rem;
  logic [SW-1:0]  acc;
  logic [SW-1:0]  bitv;
  logic [SW-1:0]  trial;
  logic [CNW-1:0] cnt;
  logic           busy;

  assign trial = acc + bitv;
  assign root  = acc[RW-1:0];

  // Control: step counter and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(RW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one trial subtraction per step.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= SW'(n);
      acc  <= '0;
      bitv <= SW'(1) << (SW - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + bitv;
      end else begin
        acc <= acc >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ----- src/nns_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.
module nns_div #(
  parameter int NW = 56,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  num_r;
  logic [DW-1:0]  den_r;
  logic [DW-1:0]  rem;
  logic [DW:0]    rem_shift;
  logic [CNW-1:0] cnt;
  logic           busy;

  assign rem_shift = {rem, num_r[NW-1]};

  // Control: step counter and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one numerator bit, compare and subtract.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      num_r <= num_r << 1;
      if (rem_shift >= {1'b0, den_r}) begin
        rem <= DW'(rem_shift - {1'b0, den_r});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/nearest_neighbor_scan_top.sv -----
// Top level of the nearest neighbor scan: sequencer, shared multiplier and accumulators.
// Depends on nns_pkg, nns_ram, nns_sqrt and nns_div.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_ready   command, element_value, last_element,
//                                            last_vector, vector_id
//   result    out        out_valid/out_ready found, best_id, best_distance, skipped_seen
//   config    in         cfg_we              cfg_wdata (metric_select)
//
// The last element of a data vector adds the finish: a square root (RW result bits, half
// the accumulator width) for euclidean; for cosine two square roots, a multiply and a
// division (NW quotient bits, the accumulator width plus 16).
// Reset is synchronous and clears all control state; the query store needs no clearing.
// A result waits in the output register while the next items are taken; only a second
// end of data set stalls until the earlier result is transferred.
module nearest_neighbor_scan_top #(
  parameter int MAX_DIM = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [15:0] element_value,
  input  logic        last_element,
  input  logic        last_vector,
  input  logic [31:0] vector_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [31:0] best_id,
  output logic [31:0] best_distance,
  output logic        skipped_seen,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import nns_pkg::*;

  localparam int CW = $clog2(MAX_DIM + 2);
  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 33 + $clog2(MAX_DIM);
  localparam int RW = (AW + 1) / 2;
  localparam int MW = RW + 1;
  localparam int NW = AW + 16;
  localparam int DW = 2 * MW;

  state_t state, state_next;

  logic               metric;
  logic signed [15:0] val_r;
  logic               last_el_r;
  logic               last_vec_r;
  logic [31:0]        vid_r;
  logic [CW-1:0]      query_length;
  logic [AW-1:0]      query_norm_sq;
  logic               query_closed;
  logic [CW-1:0]      element_count;
  logic [AW-1:0]      diff_acc;
  logic signed [AW-1:0] dot_acc;
  logic [AW-1:0]      data_norm_sq;
  logic [31:0]        best_dist_reg;
  logic [31:0]        best_id_reg;
  logic               found_flag;
  logic               skip_flag;
  logic               elem_ok;
  logic               vec_ok;
  logic signed [15:0] q_r;
  logic [RW-1:0]      mq;
  logic [31:0]        vec_dist;
  logic signed [DW-1:0] prod;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;

  logic               ram_we;
  logic [IW-1:0]      ram_addr;
  logic [15:0]        ram_rdata;

  logic               sq_start;
  logic [AW-1:0]      sq_n;
  logic [RW-1:0]      sq_root;
  logic               sq_done;

  logic               div_start;
  logic [AW-1:0]      mag;
  logic [NW-1:0]      div_quo;
  logic               div_done;
  logic [31:0]        sim;

  logic               accept;
  logic               emit_free;
  logic               emit;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign emit_free = !out_valid || out_ready;
  assign emit      = (state == S_COMPARE) && last_vec_r && emit_free;
  assign mag       = dot_acc[AW-1] ? AW'(-dot_acc) : AW'(dot_acc);
  assign sim       = (div_quo > NW'(Q_ONE)) ? Q_ONE : 32'(div_quo);

  // Query store.
  nns_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (val_r),
    .rdata (ram_rdata)
  );

  // Shared square root unit.
  nns_sqrt #(.NW(AW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .n     (sq_n),
    .root  (sq_root),
    .done  (sq_done)
  );

  // Divider for the cosine similarity.
  nns_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({mag, 16'd0}),
    .den   (DW'(prod)),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Shared multiplier operands and product register.
  always_comb begin
    mul_a = MW'(val_r);
    mul_b = MW'(val_r);
    case (state)
      S_D_MUL1: begin
        mul_a = MW'(signed'(17'(signed'(ram_rdata)) - 17'(signed'(val_r))));
        mul_b = MW'(signed'(17'(signed'(ram_rdata)) - 17'(signed'(val_r))));
      end
      S_D_MUL2: begin
        mul_a = MW'(q_r);
        mul_b = MW'(val_r);
      end
      S_COS_MUL: begin
        mul_a = signed'({1'b0, mq});
        mul_b = signed'({1'b0, sq_root});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer next state and unit controls.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr   = element_count[IW-1:0];
    sq_start   = 1'b0;
    sq_n       = (metric == METRIC_COSINE) ? query_norm_sq : diff_acc;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (command == CMD_QUERY) ? S_Q_MUL : S_D_RD;
        end
      end
      S_Q_MUL: begin
        ram_addr   = query_length[IW-1:0];
        ram_we     = (query_length < CW'(MAX_DIM));
        state_next = S_Q_ACC;
      end
      S_Q_ACC:  state_next = S_IDLE;
      S_D_RD:   state_next = S_D_MUL1;
      S_D_MUL1: state_next = S_D_MUL2;
      S_D_MUL2: state_next = S_D_MUL3;
      S_D_MUL3: state_next = S_D_ACC;
      S_D_ACC:  state_next = last_el_r ? S_F_START : S_IDLE;
      S_F_START: begin
        if (element_count != query_length || query_length > CW'(MAX_DIM)) begin
          state_next = S_COMPARE;
        end else if (metric == METRIC_EUCLID) begin
          sq_start   = 1'b1;
          state_next = S_EUC_SQ;
        end else if (query_norm_sq == '0 || data_norm_sq == '0) begin
          state_next = S_COMPARE;
        end else begin
          sq_start   = 1'b1;
          state_next = S_COS_SQ1;
        end
      end
      S_EUC_SQ: begin
        if (sq_done) begin
          state_next = S_COMPARE;
        end
      end
      S_COS_SQ1: begin
        sq_n = data_norm_sq;
        if (sq_done) begin
          sq_start   = 1'b1;
          state_next = S_COS_SQ2;
        end
      end
      S_COS_SQ2: begin
        if (sq_done) begin
          state_next = S_COS_MUL;
        end
      end
      S_COS_MUL: state_next = S_COS_DIVL;
      S_COS_DIVL: begin
        div_start  = 1'b1;
        state_next = S_COS_DIV;
      end
      S_COS_DIV: begin
        if (div_done) begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        if (!last_vec_r || emit_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register, configuration and search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      metric        <= METRIC_EUCLID;
      query_length  <= '0;
      query_norm_sq <= '0;
      query_closed  <= 1'b1;
      element_count <= '0;
      diff_acc      <= '0;
      dot_acc       <= '0;
      data_norm_sq  <= '0;
      best_dist_reg <= '1;
      best_id_reg   <= '0;
      found_flag    <= 1'b0;
      skip_flag     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        metric <= cfg_wdata;
      end
      // A new result is loaded as the previous one leaves.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_QUERY) begin
              query_closed <= last_element;
              if (query_closed) begin
                query_length  <= '0;
                query_norm_sq <= '0;
                element_count <= '0;
                diff_acc      <= '0;
                dot_acc       <= '0;
                data_norm_sq  <= '0;
              end
            end else begin
              query_closed <= 1'b1;
            end
          end
        end
        S_Q_ACC: begin
          if (query_length < CW'(MAX_DIM)) begin
            query_norm_sq <= query_norm_sq + AW'(prod);
            query_length  <= query_length + 1'b1;
          end else begin
            query_length <= CW'(MAX_DIM + 1);
          end
        end
        S_D_MUL2: begin
          if (elem_ok) begin
            diff_acc <= diff_acc + AW'(prod);
          end
        end
        S_D_MUL3: begin
          if (elem_ok) begin
            dot_acc <= dot_acc + AW'(prod);
          end
        end
        S_D_ACC: begin
          if (elem_ok) begin
            data_norm_sq <= data_norm_sq + AW'(prod);
          end
          if (element_count < CW'(MAX_DIM + 1)) begin
            element_count <= element_count + 1'b1;
          end
        end
        S_COMPARE: begin
          // Update the best vector once, then emit when the output register is free.
          if (element_count != '0 || !last_vec_r || emit_free) begin
            element_count <= '0;
            diff_acc      <= '0;
            dot_acc       <= '0;
            data_norm_sq  <= '0;
          end
          if (emit) begin
            best_dist_reg <= '1;
            best_id_reg   <= '0;
            found_flag    <= 1'b0;
            skip_flag     <= 1'b0;
          end else if (element_count != '0 || diff_acc != '0 || dot_acc != '0
                       || data_norm_sq != '0 || vec_ok) begin
            if (vec_ok) begin
              if (vec_dist < best_dist_reg) begin
                best_dist_reg <= vec_dist;
                best_id_reg   <= vid_r;
                found_flag    <= 1'b1;
              end
            end else begin
              skip_flag <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: input item, element flags, distance and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r      <= signed'(element_value);
      last_el_r  <= last_element;
      last_vec_r <= last_vector;
      vid_r      <= vector_id;
    end
    if (state == S_D_RD) begin
      elem_ok <= (element_count < query_length) && (element_count < CW'(MAX_DIM));
    end
    if (state == S_D_MUL1) begin
      q_r <= signed'(ram_rdata);
    end
    if (state == S_COS_SQ1 && sq_done) begin
      mq <= sq_root;
    end
    if (state == S_F_START) begin
      vec_ok <= (element_count == query_length) && (query_length <= CW'(MAX_DIM))
                && (metric == METRIC_EUCLID
                    || (query_norm_sq != '0 && data_norm_sq != '0));
    end
    if (state == S_EUC_SQ && sq_done) begin
      vec_dist <= 32'(sq_root);
    end
    if (state == S_COS_DIV && div_done) begin
      vec_dist <= dot_acc[AW-1] ? (Q_ONE + sim) : (Q_ONE - sim);
    end
    if (emit) begin
      found         <= found_flag || (vec_ok && vec_dist < best_dist_reg);
      best_id       <= (vec_ok && vec_dist < best_dist_reg) ? vid_r
                       : (found_flag ? best_id_reg : 32'd0);
      best_distance <= (vec_ok && vec_dist < best_dist_reg) ? vec_dist
                       : (found_flag ? best_dist_reg : 32'd0);
      skipped_seen  <= skip_flag || !vec_ok;
    end
  end

endmodule

// ----- test/nearest_neighbor_scan_top_tb.sv -----
// Testbench for nearest_neighbor_scan_top: directed and random query/data streams checked
// against an in-bench distance predictor. Depends on nns_pkg and the block's RTL only.
module nearest_neighbor_scan_top_tb;
  import nns_pkg::*;

  localparam int MAX_DIM = 128;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic        found;
    logic [31:0] id;
    logic [31:0] dist_val;
    logic        skipped;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready;
  logic        command;
  logic [15:0] element_value;
  logic        last_element, last_vector;
  logic [31:0] vector_id;
  logic        out_valid, out_ready;
  logic        found;
  logic [31:0] best_id, best_distance;
  logic        skipped_seen;
  logic        cfg_we, cfg_wdata;

  nearest_neighbor_scan_top #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .element_value(element_value),
    .last_element(last_element), .last_vector(last_vector), .vector_id(vector_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .best_id(best_id), .best_distance(best_distance),
    .skipped_seen(skipped_seen),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted search state.
  logic signed [15:0] q_mem [MAX_DIM];
  int unsigned        q_len;
  longint unsigned    q_norm;
  bit                 q_closed;
  int unsigned        elem_cnt;
  longint unsigned    diff_sq;
  longint signed      dot_sum;
  longint unsigned    d_norm;
  logic [31:0]        best_dist_p, best_id_p;
  bit                 found_p, skip_p;
  logic               metric_p;

  scan_result_t expected_results[$];
  int  items_sent, results_seen, mismatches, sets_found, sets_skipped;
  bit  tx_no_idle, rx_no_idle;
  int  rx_hold_left;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void clear_vector_acc();
    elem_cnt = 0;
    diff_sq = 0;
    dot_sum = 0;
    d_norm = 0;
  endfunction

  function automatic void clear_best();
    best_dist_p = 32'hFFFF_FFFF;
    best_id_p = 32'd0;
    found_p = 1'b0;
    skip_p = 1'b0;
  endfunction

  // Distance of the vector just finished; returns 0 when the vector is skipped.
  function automatic bit vector_distance(output logic [31:0] vd);
    longint unsigned r, den, mag, s;
    vd = 32'd0;
    if (elem_cnt != q_len || q_len > MAX_DIM) return 1'b0;
    if (metric_p == METRIC_EUCLID) begin
      r = int_sqrt(diff_sq);
      vd = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
      return 1'b1;
    end
    if (q_norm == 0 || d_norm == 0) return 1'b0;
    den = int_sqrt(q_norm) * int_sqrt(d_norm);
    mag = (dot_sum < 0) ? longint'(-dot_sum) : longint'(dot_sum);
    s = (mag << 16) / den;
    if (s > 65536) s = 65536;
    vd = (dot_sum < 0) ? Q_ONE + s[31:0] : Q_ONE - s[31:0];
    return 1'b1;
  endfunction

  // Advances the predicted state by one accepted element.
  function automatic void predict_element(input logic cmd, input logic signed [15:0] v,
                                          input logic le, input logic lv,
                                          input logic [31:0] id);
    longint signed qv, dv;
    logic [31:0] vdist;
    scan_result_t res;
    dv = v;
    if (cmd == CMD_QUERY) begin
      if (q_closed) begin
        q_len = 0;
        q_norm = 0;
        q_closed = 1'b0;
        clear_vector_acc();
      end
      if (q_len < MAX_DIM) begin
        q_mem[q_len] = v;
        q_norm += dv * dv;
        q_len++;
      end else begin
        q_len = MAX_DIM + 1;
      end
      if (le) q_closed = 1'b1;
      return;
    end
    q_closed = 1'b1;
    if (elem_cnt < q_len && elem_cnt < MAX_DIM) begin
      qv = q_mem[elem_cnt];
      diff_sq += (qv - dv) * (qv - dv);
      dot_sum += qv * dv;
      d_norm += dv * dv;
    end
    if (elem_cnt < MAX_DIM + 1) elem_cnt++;
    if (!le) return;
    if (vector_distance(vdist)) begin
      if (vdist < best_dist_p) begin
        best_dist_p = vdist;
        best_id_p = id;
        found_p = 1'b1;
      end
    end else begin
      skip_p = 1'b1;
    end
    clear_vector_acc();
    if (!lv) return;
    res.found = found_p;
    res.id = found_p ? best_id_p : 32'd0;
    res.dist_val = found_p ? best_dist_p : 32'd0;
    res.skipped = skip_p;
    expected_results = {expected_results, res};
    clear_best();
  endfunction

  // Sends one element and waits for its transfer.
  task automatic send_item(input logic cmd, input logic [15:0] v, input logic le,
                           input logic lv, input logic [31:0] id);
    while (!tx_no_idle && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    element_value <= v;
    last_element <= le;
    last_vector <= lv;
    vector_id <= id;
    do @(posedge clk); while (!in_ready);
    predict_element(cmd, v, le, lv, id);
    items_sent++;
  endtask

  // Stops offering items and waits until the block has settled.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_metric(input logic m);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    metric_p = m;
  endtask

  // Picks an element value for position idx in one of several styles.
  function automatic logic [15:0] pick_value(input int idx, input int style);
    logic [15:0] base;
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(511) - 256);
      2: begin
        base = (idx < MAX_DIM && idx < q_len) ? q_mem[idx] : 16'd0;
        return base + 16'($urandom_range(63) - 32);
      end
      3: return 16'd0;
      default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  task automatic send_query(input int len, input int style);
    for (int i = 0; i < len; i++)
      send_item(CMD_QUERY, pick_value(i, style), i == len - 1, 1'($urandom_range(1)),
                $urandom);
  endtask

  // One data vector; stray last_vector bits fall on its inner elements.
  task automatic send_vector(input int len, input int style, input logic lv,
                             input logic [31:0] id);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) send_item(CMD_DATA, pick_value(i, style), 1'b1, lv, id);
      else send_item(CMD_DATA, pick_value(i, style), 1'b0, 1'($urandom_range(1)), $urandom);
    end
  endtask

  // Receiver: checks each transfer and drives out_ready.
  always @(posedge clk) begin
    scan_result_t exp_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: found=%0b id=%h dist=%h skip=%0b",
                                         found, best_id, best_distance, skipped_seen);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.found) sets_found++;
          if (exp_r.skipped) sets_skipped++;
          if (found !== exp_r.found || best_id !== exp_r.id ||
              best_distance !== exp_r.dist_val || skipped_seen !== exp_r.skipped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp found=%0b id=%h dist=%h skip=%0b, got %0b %h %h %0b",
                       exp_r.found, exp_r.id, exp_r.dist_val, exp_r.skipped,
                       found, best_id, best_distance, skipped_seen);
          end
        end
      end
      if (rx_hold_left > 0) out_ready <= 1'b0;
      else out_ready <= rx_no_idle || $urandom_range(99) >= 24;
    end
  end

  // Counts down a long receiver hold-off.
  always @(posedge clk) begin
    if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;
  end

  // Extremes, ties, stray markers and skips under the euclidean metric.
  task automatic test_euclid_directed();
    send_item(CMD_DATA, 16'h0100, 1'b1, 1'b1, 32'h1234_5678);  // empty query skips
    send_item(CMD_QUERY, 16'h8000, 1'b0, 1'b1, 32'd0);
    send_item(CMD_QUERY, 16'h7FFF, 1'b0, 1'b0, 32'd0);
    send_item(CMD_QUERY, 16'h0000, 1'b1, 1'b0, 32'd0);
    send_item(CMD_DATA, 16'h8000, 1'b0, 1'b1, 32'd0);
    send_item(CMD_DATA, 16'h7FFF, 1'b0, 1'b0, 32'd0);
    send_item(CMD_DATA, 16'h0000, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_item(CMD_DATA, 16'h8000, 1'b0, 1'b0, 32'd1);
    send_item(CMD_DATA, 16'h7FFF, 1'b0, 1'b0, 32'd1);
    send_item(CMD_DATA, 16'h0000, 1'b1, 1'b0, 32'd2);          // tie keeps the first
    send_item(CMD_DATA, 16'h0001, 1'b0, 1'b0, 32'd3);
    send_item(CMD_DATA, 16'h0002, 1'b1, 1'b0, 32'd3);          // wrong length
    send_item(CMD_DATA, 16'h7FFF, 1'b0, 1'b0, 32'd4);
    send_item(CMD_DATA, 16'h8000, 1'b0, 1'b0, 32'd4);
    send_item(CMD_DATA, 16'hFFFF, 1'b1, 1'b1, 32'd5);
  endtask

  // Zero magnitude, opposite and parallel vectors under the cosine metric.
  task automatic test_cosine_directed();
    set_metric(METRIC_COSINE);
    send_item(CMD_QUERY, 16'h0100, 1'b0, 1'b0, 32'd0);
    send_item(CMD_QUERY, 16'h0000, 1'b1, 1'b0, 32'd0);
    send_item(CMD_DATA, 16'h0000, 1'b0, 1'b0, 32'd10);
    send_item(CMD_DATA, 16'h0000, 1'b1, 1'b0, 32'd10);
    send_item(CMD_DATA, 16'hFF00, 1'b0, 1'b0, 32'd11);
    send_item(CMD_DATA, 16'h0000, 1'b1, 1'b0, 32'd11);
    send_item(CMD_DATA, 16'h0200, 1'b0, 1'b0, 32'd12);
    send_item(CMD_DATA, 16'h0000, 1'b1, 1'b1, 32'd12);
  endtask

  // Receiver held off while short data sets keep coming, then a full drain pause.
  task automatic test_backpressure();
    rx_hold_left = 500;
    send_query(1, 1);
    for (int i = 0; i < 6; i++) send_vector(1, 1, 1'b1, $urandom);
    wait_quiet();
  endtask

  // Random query and data streams with metric changes, noise and broken vectors.
  task automatic test_random_scan(input int target);
    int start, len, nvec, next_switch, style;
    start = items_sent;
    next_switch = items_sent + 120;
    while (items_sent - start < target) begin
      tx_no_idle = (items_sent - start > 250) && (items_sent - start < 370);
      rx_no_idle = tx_no_idle;
      if ($urandom_range(99) < 14 || q_len == 0) begin
        case ($urandom_range(19))
          0: len = MAX_DIM;
          1: len = MAX_DIM + 1 + $urandom_range(1);
          default: len = 1 + $urandom_range(7);
        endcase
        send_query(len, $urandom_range(4));
      end else begin
        nvec = 1 + $urandom_range(3);
        for (int v = 0; v < nvec; v++) begin
          if (items_sent >= next_switch) begin
            set_metric(~metric_p);
            next_switch = items_sent + 100 + $urandom_range(80);
          end
          len = (q_len > MAX_DIM) ? MAX_DIM + $urandom_range(2) : q_len;
          if ($urandom_range(99) < 12) len = 1 + $urandom_range(q_len < 8 ? 8 : q_len);
          if (len > MAX_DIM && $urandom_range(3) != 0) len = 2;
          style = ($urandom_range(99) < 40) ? 2 : $urandom_range(4);
          if ($urandom_range(99) < 4) begin
            // Broken vector: a query element cuts it short.
            for (int i = 0; i < (len > 1 ? len - 1 : 1); i++)
              send_item(CMD_DATA, pick_value(i, style), 1'b0, 1'($urandom_range(1)),
                        $urandom);
            send_item(CMD_QUERY, pick_value(0, 0), 1'b1, 1'b0, $urandom);
          end else begin
            send_vector(len, style, v == nvec - 1, $urandom);
          end
        end
      end
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("nearest_neighbor_scan_top test failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_QUERY;
    element_value <= 16'd0;
    last_element <= 1'b0;
    last_vector <= 1'b0;
    vector_id <= 32'd0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= METRIC_EUCLID;
    rx_hold_left = 0;
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    foreach (q_mem[i]) q_mem[i] = 16'sd0;
    q_len = 0;
    q_norm = 0;
    q_closed = 1'b1;
    metric_p = METRIC_EUCLID;
    clear_vector_acc();
    clear_best();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_euclid_directed();
    test_cosine_directed();
    test_backpressure();
    set_metric(METRIC_EUCLID);
    test_random_scan(600);
    wait_quiet();

    $display("Sent %0d elements, checked %0d data set results (%0d found, %0d with skips).",
             items_sent, results_seen, sets_found, sets_skipped);
    $display("Both metrics, overlong and mismatched vectors, stray markers and backpressure.");
    if (mismatches == 0) begin
      $display("nearest_neighbor_scan_top test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("nearest_neighbor_scan_top test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/nns_pkg.sv
src/nns_ram.sv
src/nns_sqrt.sv
src/nns_div.sv
src/nearest_neighbor_scan_top.sv
test/nearest_neighbor_scan_top_tb.sv
